>>> rtl/tmsf_pkg.sv
// package for the trimmed mean spike filter: sizes, codes, types and helpers
`timescale 1ns / 1ps

package tmsf_pkg;

   localparam int WINDOW      = 5;
   localparam int DATA_W      = 8;
   localparam int SLOT_W      = $clog2(WINDOW);
   localparam int SUM_W       = DATA_W + $clog2(WINDOW);
   localparam int DIVISOR     = WINDOW - 2;
   localparam int CSR_INDEX_W = 2;

   // reciprocal of the divisor, exact floor for any dividend of SUM_W bits
   localparam int DIV_SHIFT = SUM_W + $clog2(DIVISOR);
   localparam int DIV_RECIP = (2 ** DIV_SHIFT + DIVISOR - 1) / DIVISOR;
   localparam int PROD_W    = SUM_W + DIV_SHIFT + 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPIKE_LIMIT   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_NEUTRAL_VALUE = CSR_INDEX_W'(1);

   localparam logic [DATA_W-1:0] SPIKE_LIMIT_RESET   = DATA_W'(10);
   localparam logic [DATA_W-1:0] NEUTRAL_VALUE_RESET = DATA_W'(127);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_LOAD,
      ST_DIV,
      ST_CHECK
   } state_type;

   // trimmed sum and its quotient for one axis
   typedef struct packed {
      logic [SUM_W-1:0]  trimmed;
      logic [DATA_W-1:0] quo;
   } div_lane_type;

   // divide the trimmed sum by window-2 through the reciprocal
   function automatic logic [DATA_W-1:0] div_trim(input logic [SUM_W-1:0] trimmed);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(trimmed) * PROD_W'(DIV_RECIP);
      return prod[DIV_SHIFT +: DATA_W];
   endfunction

   // spike test: small change from history, or exactly the neutral value
   function automatic logic spike_ok(input logic [DATA_W-1:0] avg,
                                     input logic [DATA_W-1:0] hist,
                                     input logic [DATA_W-1:0] limit,
                                     input logic [DATA_W-1:0] neutral);
      logic [DATA_W-1:0] diff;
      diff = (avg > hist) ? (avg - hist) : (hist - avg);
      return (diff < limit) || (avg == neutral);
   endfunction

endpackage

>>> rtl/trimmed_mean_spike_filter_core.sv
// top level of the trimmed mean spike filter with its sequencer and datapath
`timescale 1ns / 1ps

// a transaction accepted in idle walks the window one entry a cycle over the 5 entries,
//   then passes the load, divide and check states before its result is registered on rsp_valid
// a new transaction is taken only once the previous one has left the check state
// req_stall stays high from acceptance until the result is loaded into the output register
// reset (synchronous, active high) clears the windows, write slot, histories and the
//   registers to spike limit 10 and neutral value 127
module trimmed_mean_spike_filter_core (
   input  logic                             clock,
   input  logic                             reset,
   // sample transactions
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tmsf_pkg::DATA_W-1:0]      req_x_sample,
   input  logic [tmsf_pkg::DATA_W-1:0]      req_y_sample,
   // filtered result transactions
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tmsf_pkg::DATA_W-1:0]      rsp_x_filtered,
   output logic [tmsf_pkg::DATA_W-1:0]      rsp_y_filtered,
   output logic                             rsp_x_accepted,
   output logic                             rsp_y_accepted,
   // register writes
   input  logic                             csr_write_enable,
   input  logic [tmsf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tmsf_pkg::DATA_W-1:0]      csr_write_data
);
   import tmsf_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

   // sequencer
   state_type state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;

   // ring windows and write pointer
   logic [DATA_W-1:0] x_win_ff [WINDOW];
   logic [DATA_W-1:0] y_win_ff [WINDOW];
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // walk accumulators, one lane per axis
   logic [SUM_W-1:0]  x_sum_ff, x_sum_in, y_sum_ff, y_sum_in;
   logic [DATA_W-1:0] x_hi_ff, x_hi_in, x_lo_ff, x_lo_in;
   logic [DATA_W-1:0] y_hi_ff, y_hi_in, y_lo_ff, y_lo_in;

   // divider lanes
   div_lane_type x_div_ff, x_div_in, y_div_ff, y_div_in;

   // history and registers
   logic [DATA_W-1:0] x_hist_ff, x_hist_in, y_hist_ff, y_hist_in;
   logic [DATA_W-1:0] spike_limit_ff, neutral_value_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic              rsp_xa_ff, rsp_xa_in, rsp_ya_ff, rsp_ya_in;

   logic              accept;
   logic [DATA_W-1:0] x_rd, y_rd;
   logic              x_ok, y_ok;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // single read port per window, addressed by the walk index
   assign x_rd = x_win_ff[idx_ff];
   assign y_rd = y_win_ff[idx_ff];

   // quotient is final in the check state
   assign x_ok = spike_ok(x_div_ff.quo, x_hist_ff, spike_limit_ff, neutral_value_ff);
   assign y_ok = spike_ok(y_div_ff.quo, y_hist_ff, spike_limit_ff, neutral_value_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      x_sum_in     = x_sum_ff;
      y_sum_in     = y_sum_ff;
      x_hi_in      = x_hi_ff;
      x_lo_in      = x_lo_ff;
      y_hi_in      = y_hi_ff;
      y_lo_in      = y_lo_ff;
      x_div_in     = x_div_ff;
      y_div_in     = y_div_ff;
      x_hist_in    = x_hist_ff;
      y_hist_in    = y_hist_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_xa_in    = rsp_xa_ff;
      rsp_ya_in    = rsp_ya_ff;
      // a taken result frees the output register
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_WALK;
               idx_in   = '0;
               slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
            end
         end
         ST_WALK: begin
            if (idx_ff == '0) begin
               x_sum_in = SUM_W'(x_rd);
               y_sum_in = SUM_W'(y_rd);
               x_hi_in  = x_rd;
               x_lo_in  = x_rd;
               y_hi_in  = y_rd;
               y_lo_in  = y_rd;
            end else begin
               x_sum_in = x_sum_ff + SUM_W'(x_rd);
               y_sum_in = y_sum_ff + SUM_W'(y_rd);
               if (x_rd > x_hi_ff) x_hi_in = x_rd;
               if (x_rd < x_lo_ff) x_lo_in = x_rd;
               if (y_rd > y_hi_ff) y_hi_in = y_rd;
               if (y_rd < y_lo_ff) y_lo_in = y_rd;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_LOAD;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_LOAD: begin
            // drop one copy of each extreme
            x_div_in.trimmed = x_sum_ff - SUM_W'(x_hi_ff) - SUM_W'(x_lo_ff);
            y_div_in.trimmed = y_sum_ff - SUM_W'(y_hi_ff) - SUM_W'(y_lo_ff);
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            // reciprocal multiply in place of the divide by window-2
            x_div_in.quo = div_trim(x_div_ff.trimmed);
            y_div_in.quo = div_trim(y_div_ff.trimmed);
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            // wait here while an older result still sits in the output register
            if (!rsp_valid_ff || !rsp_stall) begin
               if (x_ok) x_hist_in = x_div_ff.quo;
               if (y_ok) y_hist_in = y_div_ff.quo;
               rsp_x_in     = x_ok ? x_div_ff.quo : x_hist_ff;
               rsp_y_in     = y_ok ? y_div_ff.quo : y_hist_ff;
               rsp_xa_in    = x_ok;
               rsp_ya_in    = y_ok;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control, windows, history and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         slot_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         x_hist_ff        <= '0;
         y_hist_ff        <= '0;
         spike_limit_ff   <= SPIKE_LIMIT_RESET;
         neutral_value_ff <= NEUTRAL_VALUE_RESET;
         for (int i = 0; i < WINDOW; i++) begin
            x_win_ff[i] <= '0;
            y_win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         x_hist_ff    <= x_hist_in;
         y_hist_ff    <= y_hist_in;
         if (accept) begin
            x_win_ff[slot_ff] <= req_x_sample;
            y_win_ff[slot_ff] <= req_y_sample;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_SPIKE_LIMIT:   spike_limit_ff   <= csr_write_data;
               CSR_NEUTRAL_VALUE: neutral_value_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      x_sum_ff   <= x_sum_in;
      y_sum_ff   <= y_sum_in;
      x_hi_ff    <= x_hi_in;
      x_lo_ff    <= x_lo_in;
      y_hi_ff    <= y_hi_in;
      y_lo_ff    <= y_lo_in;
      x_div_ff   <= x_div_in;
      y_div_ff   <= y_div_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_xa_ff  <= rsp_xa_in;
      rsp_ya_ff  <= rsp_ya_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_filtered = rsp_x_ff;
   assign rsp_y_filtered = rsp_y_ff;
   assign rsp_x_accepted = rsp_xa_ff;
   assign rsp_y_accepted = rsp_ya_ff;

`ifndef SYNTHESIS
   // an accepted transaction starts the walk at the first window entry
   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_WALK) && (idx_ff == '0))
      else $error("walk did not start after accepted transaction");

   // a new result only comes out of the check state
   a_result_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_CHECK))
      else $error("result appeared outside the check state");

   // the held output always matches the history it was taken from
   a_output_matches_history: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_x_ff == x_hist_ff) && (rsp_y_ff == y_hist_ff))
      else $error("held output differs from history");

   // the ring pointer never leaves the window
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("write slot out of range");
`endif

endmodule
